FILE: rtl/clipped_sprite_row_blit_top_defines.svh
// Assertion macros for the blitter RTL
`ifndef CLIPPED_SPRITE_ROW_BLIT_TOP_DEFINES_SVH
`define CLIPPED_SPRITE_ROW_BLIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define CSRB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blitter check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, quiet during reset
`define CSRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blitter check failed: next-cycle implication");

`endif

FILE: rtl/csrb_pkg.sv
package csrb_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned BITS_W   = 32;
    localparam int unsigned OFFS_W   = 12;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned ROW_W    = 4;
    localparam int unsigned HEIGHT_W = 8;

    localparam logic [HEIGHT_W-1:0] PLANE_HEIGHT_RESET = 8'd128;
    // leftmost column at which a sprite still shows any pixel
    localparam logic signed [POS_W:0] LEFT_LIMIT = -11'sd15;

    // one accepted beat held in the input register
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [ROW_W-1:0]        sprite_row;
        logic [WORD_W-1:0]       light_word;
        logic [WORD_W-1:0]       dark_word;
    } item_t;

endpackage

FILE: rtl/clipped_sprite_row_blit_top.sv
// Places one row of a 16x16 two-plane sprite into 1-bit framebuffer words.
// Input: raise start with pos_x, pos_y, sprite_row, light_word and dark_word;
// the beat is taken at the clock edge where start is high and busy is low.
// busy stays low, so a new row may be issued in every cycle.
// Output: done pulses for one cycle with visible, byte_offset, light_bits and
// dark_bits; the receiver must take the beat in that cycle, it cannot stall.
// Pipeline: a row passes the input register, then the result register, which
// drives done; throughput is one row per cycle, set by the single shift, mask
// and multiply-add path between the two registers.
// Configuration: cfg_valid/cfg_ready write plane_height (cfg_ready is always
// high); write it only while no row is in flight.
// Reset: rst_n clears the pipeline valid flags and sets plane_height to 128.
// A clipped row still gives a done beat with visible low and zero payload.
module clipped_sprite_row_blit_top
    import csrb_pkg::*;
#(
    parameter int SCREEN_WIDTH = 240,
    parameter int ROW_BYTES    = 30
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [POS_W-1:0]    pos_x,
    input  logic signed [POS_W-1:0]    pos_y,
    input  logic [ROW_W-1:0]           sprite_row,
    input  logic [WORD_W-1:0]          light_word,
    input  logic [WORD_W-1:0]          dark_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HEIGHT_W-1:0]        cfg_data,
    output logic                       done,
    output logic                       visible,
    output logic [OFFS_W-1:0]          byte_offset,
    output logic [BITS_W-1:0]          light_bits,
    output logic [BITS_W-1:0]          dark_bits
);

`include "clipped_sprite_row_blit_top_defines.svh"

    localparam logic signed [POS_W:0] SCREEN_W_S = (POS_W+1)'(SCREEN_WIDTH);
    localparam logic [6:0]            ROW_B      = 7'(ROW_BYTES);

    logic [HEIGHT_W-1:0] plane_height_reg;
    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic                done_reg;
    logic                visible_reg,     visible_next;
    logic [OFFS_W-1:0]   byte_offset_reg, byte_offset_next;
    logic [BITS_W-1:0]   light_bits_reg,  light_bits_next;
    logic [BITS_W-1:0]   dark_bits_reg,   dark_bits_next;

    logic                accept;
    logic signed [POS_W:0] px_s;
    logic signed [POS_W:0] ry_s;
    logic                x_ok;
    logic                y_ok;
    logic                left_clip;
    logic                right_clip;
    logic [4:0]          shift;
    logic [4:0]          drop_full;
    logic [WORD_W-1:0]   mask;
    logic [OFFS_W-1:0]   col_bytes;
    logic [16:0]         row_prod;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_height_reg <= PLANE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            plane_height_reg <= cfg_data;
        end
    end

    // advance the valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    // capture the input beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.pos_x      <= pos_x;
            s1_item_reg.pos_y      <= pos_y;
            s1_item_reg.sprite_row <= sprite_row;
            s1_item_reg.light_word <= light_word;
            s1_item_reg.dark_word  <= dark_word;
        end
    end

    // clip tests: column window and target row inside the plane
    always_comb
    begin
        px_s = {s1_item_reg.pos_x[POS_W-1], s1_item_reg.pos_x};
        ry_s = $signed({s1_item_reg.pos_y[POS_W-1], s1_item_reg.pos_y})
             + $signed({{(POS_W+1-ROW_W){1'b0}}, s1_item_reg.sprite_row});
        x_ok = (px_s >= LEFT_LIMIT) && (px_s <= SCREEN_W_S);
        y_ok = !ry_s[POS_W]
            && (ry_s[POS_W-1:0] < {{(POS_W-HEIGHT_W){1'b0}}, plane_height_reg});
    end

    // shift amount, right-edge mask, column bytes and row product
    always_comb
    begin
        left_clip  = s1_item_reg.pos_x[POS_W-1];
        shift      = 5'd16 - (left_clip ? s1_item_reg.pos_x[4:0]
                                        : {1'b0, s1_item_reg.pos_x[3:0]});
        drop_full  = 5'(px_s + 11'sd16 - SCREEN_W_S);
        right_clip = !left_clip && ((px_s + 11'sd16) > SCREEN_W_S);
        mask       = right_clip ? (16'hFFFF << drop_full) : 16'hFFFF;
        col_bytes  = left_clip ? '0
                   : {{(OFFS_W-6){1'b0}}, s1_item_reg.pos_x[8:4], 1'b0};
        row_prod   = 17'(ry_s[POS_W-1:0] * ROW_B);
    end

    // form the result beat, zero when clipped
    always_comb
    begin
        visible_next     = x_ok && y_ok;
        byte_offset_next = '0;
        light_bits_next  = '0;
        dark_bits_next   = '0;
        if (visible_next)
        begin
            byte_offset_next = row_prod[OFFS_W-1:0] + col_bytes;
            light_bits_next  = {16'h0000, s1_item_reg.light_word & mask} << shift;
            dark_bits_next   = {16'h0000, s1_item_reg.dark_word & mask} << shift;
        end
    end

    // hold the result beat
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            visible_reg     <= visible_next;
            byte_offset_reg <= byte_offset_next;
            light_bits_reg  <= light_bits_next;
            dark_bits_reg   <= dark_bits_next;
        end
    end

    assign done        = done_reg;
    assign visible     = visible_reg;
    assign byte_offset = byte_offset_reg;
    assign light_bits  = light_bits_reg;
    assign dark_bits   = dark_bits_reg;

    // pipeline checks
    `CSRB_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_reg)
    `CSRB_ASSERT_NEXT(a_stage_gives_done, s1_valid_reg, done)
    `CSRB_ASSERT_IMPL(a_clipped_is_zero, done && !visible,
        byte_offset == '0 && light_bits == '0 && dark_bits == '0)
    `CSRB_ASSERT_IMPL(a_done_needs_stage, done, $past(s1_valid_reg))

endmodule
